// ===== hw/rtl/rtx_pkg.sv =====
// ---------------------------------------------------------------------------
// rtx_pkg: shared definitions for the retransmit slot table
// Field widths, operation codes, reset values and the age-check result type.
// ---------------------------------------------------------------------------
`default_nettype none

package rtx_pkg;

   // table depth default
   localparam int SLOTS_DEFAULT = 16;

   // field widths
   localparam int OP_W       = 2;
   localparam int TIME_W     = 32;
   localparam int HANDLE_W   = 32;
   localparam int RETRY_W    = 8;
   localparam int SLOT_W     = 8;
   localparam int COUNT_W    = 9;
   localparam int INTERVAL_W = 16;

   // retry interval after reset, in seconds
   localparam logic [INTERVAL_W-1:0] RETRY_INTERVAL_RESET = 16'd3;

   // operation codes
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd0;
   localparam logic [OP_W-1:0] OP_PUSH    = 2'd1;
   localparam logic [OP_W-1:0] OP_NEXT    = 2'd2;
   localparam logic [OP_W-1:0] OP_CLEAR   = 2'd3;

   // output of the shared age check
   typedef struct packed {
      logic               due;
      logic [RETRY_W-1:0] retries_dec;
   } due_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rtx_if.sv =====
// ---------------------------------------------------------------------------
// rtx_if: channel interfaces of the retransmit slot table
// Request, response and register-write channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface rtx_req_if;
   logic                         valid;
   logic                         ready;
   logic [rtx_pkg::OP_W-1:0]     op;
   logic [rtx_pkg::TIME_W-1:0]   now_seconds;
   logic [rtx_pkg::HANDLE_W-1:0] entry_handle;
   logic [rtx_pkg::TIME_W-1:0]   entry_stamp;
   logic [rtx_pkg::RETRY_W-1:0]  entry_retries;
   logic [rtx_pkg::SLOT_W-1:0]   slot_to_clear;

   modport source (output valid, op, now_seconds, entry_handle, entry_stamp,
                   entry_retries, slot_to_clear, input ready);
   modport sink   (input valid, op, now_seconds, entry_handle, entry_stamp,
                   entry_retries, slot_to_clear, output ready);
endinterface

interface rtx_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         accepted;
   logic [rtx_pkg::SLOT_W-1:0]   slot_out;
   logic [rtx_pkg::HANDLE_W-1:0] due_handle;
   logic [rtx_pkg::RETRY_W-1:0]  retries_left;
   logic [rtx_pkg::COUNT_W-1:0]  reserved_count;

   modport source (output valid, accepted, slot_out, due_handle, retries_left,
                   reserved_count, input ready);
   modport sink   (input valid, accepted, slot_out, due_handle, retries_left,
                   reserved_count, output ready);
endinterface

interface rtx_csr_if;
   logic                           valid;
   logic                           ready;
   logic [rtx_pkg::INTERVAL_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rtx_due_unit.sv =====
// ---------------------------------------------------------------------------
// rtx_due_unit: shared age check
// Modular age of one slot against the retry interval, plus the saturating
// retry decrement applied when the slot is picked.
// ---------------------------------------------------------------------------
`default_nettype none

module rtx_due_unit (
   input  wire logic [rtx_pkg::TIME_W-1:0]     now_seconds,
   input  wire logic [rtx_pkg::TIME_W-1:0]     stamp,
   input  wire logic [rtx_pkg::INTERVAL_W-1:0] interval,
   input  wire logic [rtx_pkg::RETRY_W-1:0]    retries,
   output rtx_pkg::due_result_type             result
);

   logic [rtx_pkg::TIME_W-1:0] age;

   // age wraps modulo 2^32
   assign age = now_seconds - stamp;

   always_comb begin
      result.due         = (age >= rtx_pkg::TIME_W'(interval));
      result.retries_dec = (retries != '0) ? retries - rtx_pkg::RETRY_W'(1) : retries;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/retransmit_slot_table.sv =====
// ---------------------------------------------------------------------------
// retransmit_slot_table: message slot table for retransmission
// Reserve, push, next-due and clear operations over SLOTS slots.
// ---------------------------------------------------------------------------
// Reserve and clear go straight to DONE; push scans in PUSH, one valid bit per
// cycle, and next scans all slots in NEXT, one slot per cycle through the
// registered table read and the single age-check unit, then goes to DONE.
// One beat is in work at a time; a new beat is taken while a response waits,
// then the block stalls in DONE until it drains.
// Sync reset clears valid bits, count, interval (3) and control; table has none.
`default_nettype none

module retransmit_slot_table #(
   parameter int SLOTS = rtx_pkg::SLOTS_DEFAULT
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rtx_req_if.sink    req_ch,
   rtx_rsp_if.source  rsp_ch,
   rtx_csr_if.sink    csr_ch
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_PUSH = 2'd1;
   localparam logic [1:0] ST_NEXT = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   // slot table memory
   logic [rtx_pkg::HANDLE_W-1:0] handle_mem  [SLOTS];
   logic [rtx_pkg::TIME_W-1:0]   stamp_mem   [SLOTS];
   logic [rtx_pkg::RETRY_W-1:0]  retries_mem [SLOTS];

   logic [1:0]                     state_ff, state_in;
   logic [CNT_W-1:0]               scan_ff, scan_in;
   logic                           proc_vld_ff, proc_vld_in;
   logic [IDX_W-1:0]               proc_idx_ff, proc_idx_in;
   logic [SLOTS-1:0]               valid_ff, valid_in;
   logic [rtx_pkg::COUNT_W-1:0]    resv_ff, resv_in;
   logic [rtx_pkg::INTERVAL_W-1:0] interval_ff, interval_in;

   // captured request
   logic [rtx_pkg::TIME_W-1:0]   now_ff, now_in;
   logic [rtx_pkg::HANDLE_W-1:0] ent_handle_ff, ent_handle_in;
   logic [rtx_pkg::TIME_W-1:0]   ent_stamp_ff, ent_stamp_in;
   logic [rtx_pkg::RETRY_W-1:0]  ent_retries_ff, ent_retries_in;

   // result being built
   logic                         found_ff, found_in;
   logic [rtx_pkg::SLOT_W-1:0]   sel_slot_ff, sel_slot_in;
   logic [rtx_pkg::HANDLE_W-1:0] sel_handle_ff, sel_handle_in;
   logic [rtx_pkg::RETRY_W-1:0]  sel_rleft_ff, sel_rleft_in;

   // response register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_acc_ff, rsp_acc_in;
   logic [rtx_pkg::SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [rtx_pkg::HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [rtx_pkg::RETRY_W-1:0]  rsp_rleft_ff, rsp_rleft_in;
   logic [rtx_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   // table read data, registered from the slot scan_ff held the cycle before
   logic [rtx_pkg::HANDLE_W-1:0] rd_handle_ff;
   logic [rtx_pkg::TIME_W-1:0]   rd_stamp_ff;
   logic [rtx_pkg::RETRY_W-1:0]  rd_retries_ff;

   logic                    push_we;
   logic                    next_we;
   logic [IDX_W-1:0]        scan_idx;
   logic                    scan_live;
   logic                    req_beat;
   logic                    clear_hit;
   logic                    pick;
   logic [rtx_pkg::RETRY_W-1:0] proc_retries;
   rtx_pkg::due_result_type due_res;

   assign scan_idx  = scan_ff[IDX_W-1:0];
   assign scan_live = (scan_ff < CNT_W'(SLOTS));
   assign req_beat  = req_ch.valid && req_ch.ready;
   assign clear_hit = (rtx_pkg::COUNT_W'(req_ch.slot_to_clear) < rtx_pkg::COUNT_W'(SLOTS))
                      && valid_ff[req_ch.slot_to_clear[IDX_W-1:0]];

   // shared age check on the slot in the process stage
   rtx_due_unit u_due (
      .now_seconds (now_ff),
      .stamp       (rd_stamp_ff),
      .interval    (interval_ff),
      .retries     (rd_retries_ff),
      .result      (due_res)
   );

   assign pick         = proc_vld_ff && valid_ff[proc_idx_ff] && !found_ff && due_res.due;
   assign proc_retries = pick ? due_res.retries_dec : rd_retries_ff;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.accepted       = rsp_acc_ff;
   assign rsp_ch.slot_out       = rsp_slot_ff;
   assign rsp_ch.due_handle     = rsp_handle_ff;
   assign rsp_ch.retries_left   = rsp_rleft_ff;
   assign rsp_ch.reserved_count = rsp_count_ff;

   // sequencer and next-state logic
   always_comb begin
      state_in       = state_ff;
      scan_in        = scan_ff;
      proc_vld_in    = 1'b0;
      proc_idx_in    = scan_idx;
      valid_in       = valid_ff;
      resv_in        = resv_ff;
      interval_in    = interval_ff;
      now_in         = now_ff;
      ent_handle_in  = ent_handle_ff;
      ent_stamp_in   = ent_stamp_ff;
      ent_retries_in = ent_retries_ff;
      found_in       = found_ff;
      sel_slot_in    = sel_slot_ff;
      sel_handle_in  = sel_handle_ff;
      sel_rleft_in   = sel_rleft_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_acc_in     = rsp_acc_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_rleft_in   = rsp_rleft_ff;
      rsp_count_in   = rsp_count_ff;
      push_we        = 1'b0;
      next_we        = 1'b0;

      if (csr_ch.valid) begin
         interval_in = csr_ch.data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               now_in         = req_ch.now_seconds;
               ent_handle_in  = req_ch.entry_handle;
               ent_stamp_in   = req_ch.entry_stamp;
               ent_retries_in = req_ch.entry_retries;
               found_in       = 1'b0;
               sel_slot_in    = '0;
               sel_handle_in  = '0;
               sel_rleft_in   = '0;
               scan_in        = '0;
               unique case (req_ch.op)
                  rtx_pkg::OP_RESERVE: begin
                     if (resv_ff < rtx_pkg::COUNT_W'(SLOTS)) begin
                        resv_in  = resv_ff + rtx_pkg::COUNT_W'(1);
                        found_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  rtx_pkg::OP_PUSH: begin
                     state_in = ST_PUSH;
                  end
                  rtx_pkg::OP_NEXT: begin
                     state_in = ST_NEXT;
                  end
                  rtx_pkg::OP_CLEAR: begin
                     if (clear_hit) begin
                        valid_in[req_ch.slot_to_clear[IDX_W-1:0]] = 1'b0;
                        if (resv_ff != '0) begin
                           resv_in = resv_ff - rtx_pkg::COUNT_W'(1);
                        end
                        found_in = 1'b1;
                     end
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // lowest free slot, one valid bit per cycle
         ST_PUSH: begin
            if (!scan_live) begin
               state_in = ST_DONE;
            end else if (!valid_ff[scan_idx]) begin
               valid_in[scan_idx] = 1'b1;
               push_we            = 1'b1;
               found_in           = 1'b1;
               sel_slot_in        = rtx_pkg::SLOT_W'(scan_idx);
               state_in           = ST_DONE;
            end else begin
               scan_in = scan_ff + CNT_W'(1);
            end
         end

         // read slot scan_ff while slot proc_idx_ff goes through the age check
         ST_NEXT: begin
            if (scan_live) begin
               proc_vld_in = 1'b1;
               scan_in     = scan_ff + CNT_W'(1);
            end else begin
               state_in = ST_DONE;
            end
            if (pick) begin
               found_in      = 1'b1;
               sel_slot_in   = rtx_pkg::SLOT_W'(proc_idx_ff);
               sel_handle_in = rd_handle_ff;
               sel_rleft_in  = due_res.retries_dec;
               next_we       = 1'b1;
            end
            if (proc_vld_ff && valid_ff[proc_idx_ff] && (proc_retries == '0)) begin
               valid_in[proc_idx_ff] = 1'b0;
               if (resv_ff != '0) begin
                  resv_in = resv_ff - rtx_pkg::COUNT_W'(1);
               end
            end
         end

         // hand the result to the response register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_acc_in    = found_ff;
               rsp_slot_in   = sel_slot_ff;
               rsp_handle_in = sel_handle_ff;
               rsp_rleft_in  = sel_rleft_ff;
               rsp_count_in  = resv_ff;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         proc_vld_ff  <= 1'b0;
         valid_ff     <= '0;
         resv_ff      <= '0;
         interval_ff  <= rtx_pkg::RETRY_INTERVAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         proc_vld_ff  <= proc_vld_in;
         valid_ff     <= valid_in;
         resv_ff      <= resv_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      proc_idx_ff    <= proc_idx_in;
      now_ff         <= now_in;
      ent_handle_ff  <= ent_handle_in;
      ent_stamp_ff   <= ent_stamp_in;
      ent_retries_ff <= ent_retries_in;
      found_ff       <= found_in;
      sel_slot_ff    <= sel_slot_in;
      sel_handle_ff  <= sel_handle_in;
      sel_rleft_ff   <= sel_rleft_in;
      rsp_acc_ff     <= rsp_acc_in;
      rsp_slot_ff    <= rsp_slot_in;
      rsp_handle_ff  <= rsp_handle_in;
      rsp_rleft_ff   <= rsp_rleft_in;
      rsp_count_ff   <= rsp_count_in;
   end

   // table write port: push fills a slot, next restamps the picked one
   always_ff @(posedge clock) begin
      if (push_we) begin
         handle_mem[scan_idx]  <= ent_handle_ff;
         stamp_mem[scan_idx]   <= ent_stamp_ff;
         retries_mem[scan_idx] <= ent_retries_ff;
      end else if (next_we) begin
         stamp_mem[proc_idx_ff]   <= now_ff;
         retries_mem[proc_idx_ff] <= due_res.retries_dec;
      end
   end

   // table read port, registered
   always_ff @(posedge clock) begin
      if (scan_live) begin
         rd_handle_ff  <= handle_mem[scan_idx];
         rd_stamp_ff   <= stamp_mem[scan_idx];
         rd_retries_ff <= retries_mem[scan_idx];
      end
   end

endmodule

`default_nettype wire
